// File: hw/rtl/thn_pkg.sv
`timescale 1ns / 1ps
package thn_pkg;

  // fixed field widths of the channels
  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CNT_W    = 9;
  localparam int unsigned REV_W    = 32;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_PREV   = 2'd1,
    OP_NEXT   = 2'd2,
    OP_CLEAR  = 2'd3
  } thn_op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 2'd0,
    STS_INVALID  = 2'd1,
    STS_NOTFOUND = 2'd2
  } thn_status_e;

  // per-cycle move of the cell row
  typedef struct packed {
    logic shift;   // append: every cell takes the entry of its newer neighbor
    logic rotate;  // scan: every cell takes the entry of the next cell
  } thn_cell_ctl_t;

endpackage

// File: hw/rtl/thn_if.sv
`timescale 1ns / 1ps
interface thn_in_if;
  import thn_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [KEY_W-1:0]    group_key;
  logic [WORD_W-1:0]   payload_word;
  logic                payload_valid;
  logic [WORD_W-1:0]   seq_number;
  logic [WORD_W-1:0]   publish_time;
  modport source (output valid, opcode, group_key, payload_word, payload_valid,
                  seq_number, publish_time, input ready);
  modport sink (input valid, opcode, group_key, payload_word, payload_valid,
                seq_number, publish_time, output ready);
endinterface

interface thn_out_if;
  import thn_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    hit_key;
  logic [WORD_W-1:0]   hit_payload;
  logic [WORD_W-1:0]   hit_sequence;
  logic [WORD_W-1:0]   hit_time;
  logic [CNT_W-1:0]    entry_count;
  logic [CNT_W-1:0]    cursor_pos;
  logic [REV_W-1:0]    revision;
  modport source (output valid, status, hit_key, hit_payload, hit_sequence, hit_time,
                  entry_count, cursor_pos, revision, input ready);
  modport sink (input valid, status, hit_key, hit_payload, hit_sequence, hit_time,
                entry_count, cursor_pos, revision, output ready);
endinterface

// File: hw/rtl/thn_cell.sv
`timescale 1ns / 1ps
module thn_cell #(
  parameter int unsigned EntryW = 8
) (
  input  logic                  clk_i,
  input  thn_pkg::thn_cell_ctl_t ctl_i,
  input  logic [EntryW-1:0]     newer_i,
  input  logic [EntryW-1:0]     next_i,
  output logic [EntryW-1:0]     entry_o
);
  import thn_pkg::*;

  logic [EntryW-1:0] entry_q;
  logic [EntryW-1:0] entry_d;

  // pick the neighbor for this cycle's move
  always_comb begin
    priority if (ctl_i.shift) begin
      entry_d = newer_i;
    end else if (ctl_i.rotate) begin
      entry_d = next_i;
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: hw/rtl/tagged_history_navigator.sv
`timescale 1ns / 1ps
// Tagged history navigator
// Input channel in_i carries one command item: append, previous, next or clear,
// with the key and the entry fields. Output channel out_o returns one result
// item per command: status, the hit entry, entry count, cursor and revision.
// Entries live in a row of HISTORY_DEPTH cells, newest in cell 0. Append shifts
// the row by one cell (the oldest falls off the far end when full) and clear
// resets the count and cursor without touching the cells. For both, the result
// is loaded into the output register on the edge that takes the command, and
// with a ready receiver a new command can be taken on the next edge.
// Previous and next rotate the whole row once around, one cell per cycle past
// the compare tap at cell 0, which leaves the row as it was, whatever the count.
// The result is loaded into the output register after the rotation, once that
// register is free.
// A new command is taken only while no search runs and the output register is
// free or being emptied in the same cycle; a stalled receiver holds the result
// in place and holds off the next command.
// Reset empties the history, zeroes the cursor and sets the revision to 1;
// cell contents are not cleared and are never read before being written.
module tagged_history_navigator #(
  parameter int unsigned HISTORY_DEPTH = 256,
  parameter int unsigned KEY_BITS      = 32,
  parameter int unsigned PAYLOAD_BITS  = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  thn_in_if.sink    in_i,
  thn_out_if.source out_o
);
  import thn_pkg::*;

  localparam int unsigned AW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned KSW  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int unsigned PW   = PAYLOAD_BITS;
  localparam int unsigned EW   = KSW + PW + 2 * WORD_W;
  localparam int unsigned PLO  = 2 * WORD_W;
  localparam int unsigned KLO  = 2 * WORD_W + PW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state_q;
  logic [CW-1:0]    count_q;
  logic [CW-1:0]    cursor_q;
  logic [REV_W-1:0] rev_q;
  logic [AW-1:0]    step_q;
  logic [CW-1:0]    bound_q;
  logic             is_prev_q;
  logic [KSW-1:0]   key_q;
  logic             found_q;
  logic [CW-1:0]    hit_pos_q;
  logic [EW-1:0]    hit_q;

  logic                out_valid_q;
  logic [STATUS_W-1:0] o_status_q;
  logic [EW-1:0]       o_hit_q;
  logic [CW-1:0]       o_count_q;
  logic [CW-1:0]       o_cursor_q;
  logic [REV_W-1:0]    o_rev_q;

  logic [EW-1:0]  cells [HISTORY_DEPTH];
  logic [EW-1:0]  new_entry;
  thn_cell_ctl_t  ctl;
  logic           out_free;
  logic           in_take;
  logic           do_append;
  logic [CW-1:0]  cnt_app;
  logic [CW-1:0]  start_prev;
  logic [CW-1:0]  start_next;
  logic [CW-1:0]  step_ext;
  logic [CW-1:0]  pos;
  logic           in_rng;
  logic           match;
  logic           last_step;

  // handshake
  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign in_take    = in_i.valid && in_i.ready;
  assign do_append  = in_take && (in_i.opcode == OP_APPEND) && in_i.payload_valid;

  // entry packed as key, payload, sequence, time
  assign new_entry = {in_i.group_key[KSW-1:0], in_i.payload_word[PW-1:0],
                      in_i.seq_number, in_i.publish_time};

  assign ctl.shift  = do_append;
  assign ctl.rotate = (state_q == ST_SCAN);

  // row of cells, newest at cell 0
  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    thn_cell #(.EntryW(EW)) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .newer_i ((i == 0) ? new_entry : cells[(i + HISTORY_DEPTH - 1) % HISTORY_DEPTH]),
      .next_i  (cells[(i + 1) % HISTORY_DEPTH]),
      .entry_o (cells[i])
    );
  end

  // count after an append, and search bounds
  assign cnt_app    = (count_q == CW'(HISTORY_DEPTH)) ? count_q : count_q + CW'(1);
  assign start_prev = (cursor_q > count_q) ? count_q : cursor_q;
  assign start_next = (cursor_q < count_q) ? cursor_q + CW'(1) : count_q;

  // tap at cell 0 holds logical position count-1-step
  assign step_ext  = CW'(step_q);
  assign in_rng    = step_ext < count_q;
  assign pos       = count_q - CW'(1) - step_ext;
  assign last_step = (step_q == AW'(HISTORY_DEPTH - 1));
  assign match     = in_rng && (cells[0][KLO +: KSW] == key_q) &&
                     (is_prev_q ? ((pos < bound_q) && !found_q) : (pos >= bound_q));

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cursor_q    <= '0;
      rev_q       <= REV_W'(1);
      step_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_take) begin
            unique case (in_i.opcode)
              OP_APPEND: begin
                out_valid_q <= 1'b1;
                if (in_i.payload_valid) begin
                  count_q  <= cnt_app;
                  cursor_q <= cnt_app;
                  rev_q    <= rev_q + REV_W'(1);
                end
              end
              OP_CLEAR: begin
                out_valid_q <= 1'b1;
                count_q     <= '0;
                cursor_q    <= '0;
                rev_q       <= rev_q + REV_W'(1);
              end
              default: begin
                state_q <= ST_SCAN;
                step_q  <= '0;
                found_q <= 1'b0;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (match) begin
            found_q <= 1'b1;
          end
          step_q <= step_q + AW'(1);
          if (last_step) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
            if (found_q) begin
              cursor_q <= hit_pos_q;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // search operands and hit capture
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      is_prev_q <= (in_i.opcode == OP_PREV);
      key_q     <= in_i.group_key[KSW-1:0];
      bound_q   <= (in_i.opcode == OP_PREV) ? start_prev : start_next;
    end
    if ((state_q == ST_SCAN) && match) begin
      hit_q     <= cells[0];
      hit_pos_q <= pos;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (in_take && (in_i.opcode == OP_APPEND)) begin
      o_status_q <= in_i.payload_valid ? STS_OK : STS_INVALID;
      o_hit_q    <= '0;
      o_count_q  <= in_i.payload_valid ? cnt_app : count_q;
      o_cursor_q <= in_i.payload_valid ? cnt_app : cursor_q;
      o_rev_q    <= in_i.payload_valid ? rev_q + REV_W'(1) : rev_q;
    end else if (in_take && (in_i.opcode == OP_CLEAR)) begin
      o_status_q <= STS_OK;
      o_hit_q    <= '0;
      o_count_q  <= '0;
      o_cursor_q <= '0;
      o_rev_q    <= rev_q + REV_W'(1);
    end else if ((state_q == ST_DONE) && out_free) begin
      o_status_q <= found_q ? STS_OK : STS_NOTFOUND;
      o_hit_q    <= found_q ? hit_q : '0;
      o_count_q  <= count_q;
      o_cursor_q <= found_q ? hit_pos_q : cursor_q;
      o_rev_q    <= rev_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = o_status_q;
  assign out_o.hit_key      = KEY_W'(o_hit_q[KLO +: KSW]);
  assign out_o.hit_payload  = WORD_W'(o_hit_q[PLO +: PW]);
  assign out_o.hit_sequence = o_hit_q[WORD_W +: WORD_W];
  assign out_o.hit_time     = o_hit_q[WORD_W-1:0];
  assign out_o.entry_count  = CNT_W'(o_count_q);
  assign out_o.cursor_pos   = CNT_W'(o_cursor_q);
  assign out_o.revision     = o_rev_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(HISTORY_DEPTH))
    else $error("entry count beyond history depth");

  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= count_q)
    else $error("cursor beyond entry count");

  a_scan_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |=> $stable(count_q) && $stable(rev_q))
    else $error("history changed during a search");

  a_done_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && out_free |=> out_valid_q && (state_q == ST_IDLE))
    else $error("search finished without a result item");

endmodule
